@@ rtl/ffha_pkg.sv @@
// Package with the sizes, table types and sequencer states of the heap allocator.
`default_nettype none
package ffha_pkg;
  localparam int HeapBytes   = 4096;
  localparam int HeaderBytes = 32;
  localparam int MaxSegments = 128;
  localparam int IdxW  = $clog2(MaxSegments);
  localparam int CntW  = $clog2(MaxSegments + 1);
  localparam int AddrW = 12;
  localparam int SizeW = 13;
  localparam int ReqW  = 16;

  typedef enum logic [0:0] {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef struct packed {
    logic [AddrW-1:0] payload;
    logic [SizeW-1:0] bytes;
    logic             is_free;
  } seg_t;

  typedef enum logic [3:0] {
    StIdle, StScan, StScanWait, StDecide, StShiftUp, StInsert,
    StMergeNext, StMergePrev, StDrop, StDone
  } state_e;
endpackage
`default_nettype wire

@@ rtl/ffha_seg_ram.sv @@
// Segment table memory with one write port and one registered read port.
`default_nettype none
module ffha_seg_ram (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [ffha_pkg::IdxW-1:0] waddr_i,
  input  wire ffha_pkg::seg_t        wdata_i,
  input  wire logic [ffha_pkg::IdxW-1:0] raddr_i,
  output ffha_pkg::seg_t             rdata_o
);
  import ffha_pkg::*;
  seg_t mem [MaxSegments];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/first_fit_heap_allocator_unit.sv @@
// First-fit heap allocator: sequencer over a segment table kept in memory.
//
// Input channel (valid/ready) carries op, req_size and payload_addr. Output
// channel (valid/ready) returns payload_out and ok, one result per input.
// The block handles one item at a time and is not ready while it works.
// The segment table lives in a single-port-write, single-port-read memory,
// so every table access goes through that port. An item scans the table from
// position 0 to find its segment; a split then shifts entries up or a merge
// shifts them down, one entry at a time.
// The result sits in an output register; while the receiver stalls the block
// holds it and accepts nothing new. After reset the table is rebuilt by a
// clearing pass that writes entry 0 before the first transfer; entries
// beyond the fill count are never read, so no further sweep is needed.
`default_nettype none
module first_fit_heap_allocator_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [0:0]                  op_i,
  input  wire logic [ffha_pkg::ReqW-1:0]   req_size_i,
  input  wire logic [ffha_pkg::AddrW-1:0]  payload_addr_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [ffha_pkg::AddrW-1:0]       payload_out_o,
  output logic                             ok_o
);
  import ffha_pkg::*;

  state_e state_q, state_d;
  logic             init_q, init_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  k_q, k_d;
  logic             op_q, op_d;
  logic [ReqW+1:0]  need_q, need_d;
  logic [AddrW-1:0] addr_q, addr_d;
  seg_t             cur_q, cur_d;
  seg_t             hold_q, hold_d;
  logic             ovalid_q, ovalid_d;
  logic [AddrW-1:0] pout_q, pout_d;
  logic             ok_q, ok_d;

  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  seg_t             wdata, rdata;
  logic [ReqW+1:0]  need_hdr;
  logic [ReqW+1:0]  big_bytes;

  ffha_seg_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign need_hdr   = need_q + (ReqW+2)'(HeaderBytes);
  assign big_bytes  = (ReqW+2)'(rdata.bytes);

  always_comb begin
    state_d = state_q; init_d = init_q; cnt_d = cnt_q; idx_d = idx_q; k_d = k_q;
    op_d = op_q; need_d = need_q; addr_d = addr_q; cur_d = cur_q; hold_d = hold_q;
    ovalid_d = ovalid_q; pout_d = pout_q; ok_d = ok_q;
    we = 1'b0; waddr = idx_q; wdata = cur_q; raddr = idx_q;
    in_ready_o = 1'b0;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (!init_q) begin
          we = 1'b1; waddr = '0;
          wdata = '{payload: AddrW'(HeaderBytes),
                    bytes: SizeW'(HeapBytes - HeaderBytes), is_free: 1'b1};
          init_d = 1'b1;
        end else if (!ovalid_q) begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            op_d = op_i; addr_d = payload_addr_i;
            need_d = ((ReqW+2)'(req_size_i) + (ReqW+2)'(3)) & ~(ReqW+2)'(3);
            idx_d = '0;
            hold_d = '0;
            if (op_i == OpAlloc && req_size_i == '0) begin
              ok_d = 1'b0; pout_d = '0; state_d = StDone;
            end else begin
              state_d = StScan;
            end
          end
        end
      end
      StScan: begin
        raddr = idx_q; state_d = StScanWait;
      end
      StScanWait: begin
        state_d = StDecide;
      end
      StDecide: begin
        cur_d = rdata;
        if (op_q == OpAlloc && rdata.is_free && big_bytes >= need_hdr) begin
          if (big_bytes == need_hdr) begin
            we = 1'b1; waddr = idx_q;
            wdata = '{payload: rdata.payload, bytes: rdata.bytes, is_free: 1'b0};
            ok_d = 1'b1; pout_d = rdata.payload; state_d = StDone;
          end else if (cnt_q >= CntW'(MaxSegments)) begin
            ok_d = 1'b0; pout_d = '0; state_d = StDone;
          end else begin
            k_d = cnt_q; state_d = StShiftUp;
          end
        end else if (op_q == OpFree && rdata.payload == addr_q) begin
          we = 1'b1; waddr = idx_q;
          wdata = '{payload: rdata.payload, bytes: rdata.bytes, is_free: 1'b1};
          cur_d.is_free = 1'b1;
          ok_d = 1'b1; pout_d = '0;
          k_d = CntW'(idx_q) + CntW'(1);
          state_d = StMergeNext;
        end else if (CntW'(idx_q) + CntW'(1) >= cnt_q) begin
          ok_d = 1'b0; pout_d = '0; state_d = StDone;
        end else begin
          idx_d = idx_q + IdxW'(1); raddr = idx_q + IdxW'(1); state_d = StScanWait;
        end
      end
      StShiftUp: begin
        // k_q walks down from seg_count; read k-1, then write it at k.
        if (k_q > CntW'(idx_q) + CntW'(1)) begin
          raddr = IdxW'(k_q - CntW'(1));
          hold_d.is_free = 1'b0;
          state_d = StInsert;
          hold_d = '{payload: '0, bytes: '0, is_free: 1'b0};
        end else begin
          we = 1'b1; waddr = idx_q + IdxW'(1);
          wdata = '{payload: AddrW'((ReqW+2)'(cur_q.payload) + need_hdr),
                    bytes: SizeW'((ReqW+2)'(cur_q.bytes) - need_hdr), is_free: 1'b1};
          cnt_d = cnt_q + CntW'(1);
          hold_d = '{payload: cur_q.payload, bytes: '0, is_free: 1'b1};
          state_d = StInsert;
        end
      end
      StInsert: begin
        if (hold_q.is_free) begin
          we = 1'b1; waddr = idx_q;
          wdata = '{payload: cur_q.payload, bytes: SizeW'(need_q), is_free: 1'b0};
          ok_d = 1'b1; pout_d = cur_q.payload; state_d = StDone;
        end else begin
          we = 1'b1; waddr = IdxW'(k_q); wdata = rdata;
          k_d = k_q - CntW'(1); state_d = StShiftUp;
        end
      end
      StMergeNext: begin
        // Phase 0 (hold_q.is_free low): issue read of neighbour; phase 1: use it.
        if (k_q >= cnt_q) begin
          k_d = CntW'(idx_q); state_d = StMergePrev; hold_d.is_free = 1'b0;
        end else if (!hold_q.is_free) begin
          raddr = IdxW'(k_q); hold_d.is_free = 1'b1;
        end else begin
          hold_d.is_free = 1'b0;
          if (rdata.is_free) begin
            cur_d.bytes = cur_q.bytes + SizeW'(HeaderBytes) + rdata.bytes;
            we = 1'b1; waddr = idx_q;
            wdata = '{payload: cur_q.payload,
                      bytes: cur_q.bytes + SizeW'(HeaderBytes) + rdata.bytes,
                      is_free: 1'b1};
            state_d = StDrop;
            hold_d.payload = AddrW'(1);
          end else begin
            k_d = CntW'(idx_q); state_d = StMergePrev;
          end
        end
      end
      StMergePrev: begin
        if (idx_q == '0) begin
          state_d = StDone;
        end else if (!hold_q.is_free) begin
          raddr = idx_q - IdxW'(1); hold_d.is_free = 1'b1;
        end else begin
          hold_d.is_free = 1'b0;
          if (rdata.is_free) begin
            we = 1'b1; waddr = idx_q - IdxW'(1);
            wdata = '{payload: rdata.payload,
                      bytes: rdata.bytes + SizeW'(HeaderBytes) + cur_q.bytes,
                      is_free: 1'b1};
            k_d = CntW'(idx_q);
            hold_d.payload = '0;
            state_d = StDrop;
          end else begin
            state_d = StDone;
          end
        end
      end
      StDrop: begin
        // Move entry k+1 down to k for k from the dropped slot upward.
        // hold_q.payload[0] marks a drop that follows the next-side merge.
        if (k_q + CntW'(1) >= cnt_q) begin
          cnt_d = cnt_q - CntW'(1);
          hold_d.bytes = '0;
          if (hold_q.payload[0]) begin
            k_d = CntW'(idx_q); state_d = StMergePrev; hold_d.payload = '0;
          end else begin
            state_d = StDone;
          end
        end else if (!hold_q.is_free) begin
          raddr = IdxW'(k_q + CntW'(1)); hold_d.is_free = 1'b1;
        end else begin
          we = 1'b1; waddr = IdxW'(k_q); wdata = rdata;
          hold_d.is_free = 1'b0; k_d = k_q + CntW'(1);
        end
      end
      StDone: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; init_q <= 1'b0; cnt_q <= CntW'(1);
      ovalid_q <= 1'b0; hold_q <= '0; k_q <= '0; idx_q <= '0;
    end else begin
      state_q <= state_d; init_q <= init_d; cnt_q <= cnt_d;
      ovalid_q <= ovalid_d; hold_q <= hold_d; k_q <= k_d; idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; need_q <= need_d; addr_q <= addr_d; cur_q <= cur_d;
    pout_q <= pout_d; ok_q <= ok_d;
  end

  assign out_valid_o   = ovalid_q;
  assign payload_out_o = pout_q;
  assign ok_o          = ok_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == StIdle && !ovalid_q)) else $error("ready while busy");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q >= CntW'(1) && cnt_q <= CntW'(MaxSegments))) else $error("count range");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> payload_out_o == '0) else $error("failed result nonzero");
  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o) else $error("result too early");
endmodule
`default_nettype wire
